// ----- hw/rtl/wpool_pkg.sv -----
// Shared constants, types and helpers of the window pooling block.
package wpool_pkg;

    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 11;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_SIZE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_POOL_MODE   = 2'd2;

    localparam logic [CFG_DATA_BITS-1:0] ROW_WIDTH_RESET = 11'd1024;
    localparam logic [1:0]               WINDOW_RESET    = 2'd2;
    localparam logic                     MODE_RESET      = 1'b0;
    localparam logic [1:0]               WINDOW_THREE    = 2'd3;
    localparam logic                     MODE_AVG        = 1'b1;

    localparam int ACC_GUARD    = 4;
    localparam int ACC_MAX_BITS = 36;

    localparam logic [15:0] DIV3_MUL   = 16'd43691;
    localparam int          DIV3_SHIFT = 17;

    localparam int                 AVG_K_BITS = 14;
    localparam logic signed [13:0] AVG3_MUL   = 14'sd7282;
    localparam int                 AVG3_SHIFT = 16;
    localparam int                 AVG2_SHIFT = 2;

    localparam int OUT_DEPTH = 4;

    typedef struct packed {
        logic three;
        logic avg;
    } wpool_cfg_t;

    typedef struct packed {
        logic valid;
        logic first_row;
        logic last_row;
        logic row_end;
    } wpool_op_t;

    function automatic logic signed [ACC_MAX_BITS-1:0] combine(
        input logic signed [ACC_MAX_BITS-1:0] a,
        input logic signed [ACC_MAX_BITS-1:0] b,
        input logic                           avg
    );
        if (avg == MODE_AVG) begin
            return a + b;
        end
        return (b > a) ? b : a;
    endfunction

endpackage

// ----- hw/rtl/wpool_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module wpool_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 512,
    localparam int AB   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AB-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AB-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/wpool_ctrl.sv -----
// Configuration registers, position counters, row accumulator and line store read.
module wpool_ctrl #(
    parameter int MAX_WIDTH   = wpool_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = wpool_pkg::SAMPLE_BITS_DEF,
    localparam int SD         = MAX_WIDTH / 2,
    localparam int AB         = (SD > 1) ? $clog2(SD) : 1,
    localparam int AW         = SAMPLE_BITS + wpool_pkg::ACC_GUARD
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [wpool_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [wpool_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    input  logic                                   in_accept,
    input  logic signed [SAMPLE_BITS-1:0]          in_sample,
    input  logic                                   in_tensor_start,
    output wpool_pkg::wpool_cfg_t                  cfg,
    output logic                                   rd_en,
    output logic [AB-1:0]                          rd_addr,
    output wpool_pkg::wpool_op_t                   op,
    output logic signed [AW-1:0]                   op_acc,
    output logic [AB-1:0]                          op_idx
);
    import wpool_pkg::*;

    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int OB = $clog2(SD + 1);
    localparam int WIDTH_RST  = (int'(ROW_WIDTH_RESET) > MAX_WIDTH) ? MAX_WIDTH
                                                                    : int'(ROW_WIDTH_RESET);
    localparam int OUTS_RST   = WIDTH_RST / 2;
    localparam int USABLE_RST = OUTS_RST * 2;

    logic [CFG_DATA_BITS-1:0] row_width_reg, row_width_next;
    logic [1:0]               window_reg, window_next;
    logic                     mode_reg, mode_next;
    logic [WB-1:0]            width_reg, width_next;
    logic [OB-1:0]            outs_reg, outs_next;
    logic [WB-1:0]            usable_reg, usable_next;

    logic [31:0] w32, prod32, outs32, usable32;
    logic        three_next;

    logic [WB-1:0]        ic_reg, ic_next, ic_cur;
    logic [1:0]           cw_reg, cw_next, cw_cur;
    logic [1:0]           rw_reg, rw_next, rw_cur;
    logic [OB-1:0]        oc_reg, oc_next, oc_cur;
    logic signed [AW-1:0] hacc_reg, hacc_next, hacc_cur;

    logic signed [ACC_MAX_BITS-1:0] x_w, hacc_w, acc_w;
    logic [2:0]     f_w, cw_inc, rw_inc;
    logic [WB:0]    ic_inc;
    logic [OB:0]    oc_inc;
    logic [OB-1:0]  idx_w;
    logic           active, done, rw_last;

    wpool_op_t            op_reg, op_next;
    logic signed [AW-1:0] op_acc_reg;
    logic [AB-1:0]        op_idx_reg;

    always_comb begin
        row_width_next = row_width_reg;
        window_next    = window_reg;
        mode_next      = mode_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ROW_WIDTH:   row_width_next = cfg_wdata;
                CFG_WINDOW_SIZE: window_next    = cfg_wdata[1:0];
                CFG_POOL_MODE:   mode_next      = cfg_wdata[0];
                default: ;
            endcase
        end
        three_next = (window_next == WINDOW_THREE);
        w32 = 32'(row_width_next);
        if (w32 == 32'd0) begin
            w32 = 32'd1;
        end else if (w32 > 32'(MAX_WIDTH)) begin
            w32 = 32'(MAX_WIDTH);
        end
        prod32   = w32 * 32'(DIV3_MUL);
        outs32   = three_next ? (prod32 >> DIV3_SHIFT) : (w32 >> 1);
        usable32 = three_next ? (outs32 + (outs32 << 1)) : (outs32 << 1);
        width_next  = w32[WB-1:0];
        outs_next   = outs32[OB-1:0];
        usable_next = usable32[WB-1:0];
    end

    always_comb begin
        ic_cur   = in_tensor_start ? '0 : ic_reg;
        cw_cur   = in_tensor_start ? '0 : cw_reg;
        rw_cur   = in_tensor_start ? '0 : rw_reg;
        oc_cur   = in_tensor_start ? '0 : oc_reg;
        hacc_cur = in_tensor_start ? '0 : hacc_reg;

        f_w    = (window_reg == WINDOW_THREE) ? 3'd3 : 3'd2;
        x_w    = ACC_MAX_BITS'(in_sample);
        hacc_w = ACC_MAX_BITS'(hacc_cur);
        acc_w  = (cw_cur == 2'd0) ? x_w : combine(hacc_w, x_w, mode_reg);

        active  = (ic_cur < usable_reg);
        cw_inc  = {1'b0, cw_cur} + 3'd1;
        done    = active && (cw_inc >= f_w);
        rw_inc  = {1'b0, rw_cur} + 3'd1;
        rw_last = (rw_inc >= f_w);
        oc_inc  = {1'b0, oc_cur} + 1'b1;
        ic_inc  = {1'b0, ic_cur} + 1'b1;

        idx_w = (oc_cur >= OB'(SD)) ? (oc_cur - OB'(SD)) : oc_cur;

        hacc_next = active ? acc_w[AW-1:0] : hacc_cur;
        cw_next   = active ? (done ? 2'd0 : cw_inc[1:0]) : cw_cur;
        oc_next   = done ? oc_inc[OB-1:0] : oc_cur;
        rw_next   = rw_cur;
        ic_next   = ic_inc[WB-1:0];
        if (ic_inc >= {1'b0, width_reg}) begin
            ic_next = '0;
            oc_next = '0;
            cw_next = '0;
            rw_next = rw_last ? 2'd0 : rw_inc[1:0];
        end

        op_next.valid     = in_accept && done;
        op_next.first_row = (rw_cur == 2'd0);
        op_next.last_row  = rw_last;
        op_next.row_end   = (oc_inc >= {1'b0, outs_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg <= ROW_WIDTH_RESET;
            window_reg    <= WINDOW_RESET;
            mode_reg      <= MODE_RESET;
            width_reg     <= WB'(WIDTH_RST);
            outs_reg      <= OB'(OUTS_RST);
            usable_reg    <= WB'(USABLE_RST);
            ic_reg        <= '0;
            cw_reg        <= '0;
            rw_reg        <= '0;
            oc_reg        <= '0;
            hacc_reg      <= '0;
            op_reg        <= '0;
        end else begin
            row_width_reg <= row_width_next;
            window_reg    <= window_next;
            mode_reg      <= mode_next;
            width_reg     <= width_next;
            outs_reg      <= outs_next;
            usable_reg    <= usable_next;
            if (in_accept) begin
                ic_reg   <= ic_next;
                cw_reg   <= cw_next;
                rw_reg   <= rw_next;
                oc_reg   <= oc_next;
                hacc_reg <= hacc_next;
            end
            op_reg <= op_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            op_acc_reg <= acc_w[AW-1:0];
            op_idx_reg <= idx_w[AB-1:0];
        end
    end

    assign cfg.three = (window_reg == WINDOW_THREE);
    assign cfg.avg   = mode_reg;
    assign rd_en     = op_next.valid;
    assign rd_addr   = idx_w[AB-1:0];
    assign op        = op_reg;
    assign op_acc    = op_acc_reg;
    assign op_idx    = op_idx_reg;

endmodule

// ----- hw/rtl/wpool_merge.sv -----
// Merge with the line store entry, write back, then scale and saturate the pooled word.
module wpool_merge #(
    parameter int MAX_WIDTH   = wpool_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = wpool_pkg::SAMPLE_BITS_DEF,
    localparam int SD         = MAX_WIDTH / 2,
    localparam int AB         = (SD > 1) ? $clog2(SD) : 1,
    localparam int AW         = SAMPLE_BITS + wpool_pkg::ACC_GUARD
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  wpool_pkg::wpool_cfg_t         cfg,
    input  wpool_pkg::wpool_op_t          op,
    input  logic signed [AW-1:0]          op_acc,
    input  logic [AB-1:0]                 op_idx,
    input  logic [AW-1:0]                 rd_data,
    output logic                          wr_en,
    output logic [AB-1:0]                 wr_addr,
    output logic [AW-1:0]                 wr_data,
    output logic                          push,
    output logic [SAMPLE_BITS-1:0]        push_data,
    output logic                          push_last,
    output logic [1:0]                    pending
);
    import wpool_pkg::*;

    localparam int PW = AW + AVG_K_BITS;
    localparam logic signed [PW-1:0] SAT_HI = PW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [PW-1:0] SAT_LO = ~SAT_HI;

    logic signed [ACC_MAX_BITS-1:0] acc_w, rd_w, merged_w;
    logic signed [AW-1:0]           v_w;

    logic                 s2_valid_reg;
    logic signed [AW-1:0] s2_v_reg;
    logic                 s2_last_reg;

    logic signed [PW-1:0] v_ext, prod, scaled, sat;

    always_comb begin
        acc_w    = ACC_MAX_BITS'(op_acc);
        rd_w     = ACC_MAX_BITS'($signed(rd_data));
        merged_w = op.first_row ? acc_w : combine(rd_w, acc_w, cfg.avg);
        v_w      = merged_w[AW-1:0];
    end

    assign wr_en   = op.valid;
    assign wr_addr = op_idx;
    assign wr_data = v_w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= op.valid && op.last_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (op.valid) begin
            s2_v_reg    <= v_w;
            s2_last_reg <= op.row_end;
        end
    end

    always_comb begin
        v_ext = PW'(s2_v_reg);
        prod  = s2_v_reg * AVG3_MUL;
        if (cfg.avg != MODE_AVG) begin
            scaled = v_ext;
        end else if (cfg.three) begin
            scaled = prod >>> AVG3_SHIFT;
        end else begin
            scaled = v_ext >>> AVG2_SHIFT;
        end
        priority if (scaled < SAT_LO) begin
            sat = SAT_LO;
        end else if (scaled > SAT_HI) begin
            sat = SAT_HI;
        end else begin
            sat = scaled;
        end
    end

    assign push      = s2_valid_reg;
    assign push_data = sat[SAMPLE_BITS-1:0];
    assign push_last = s2_last_reg;
    assign pending   = {1'b0, op.valid && op.last_row} + {1'b0, s2_valid_reg};

endmodule

// ----- hw/rtl/wpool_fifo.sv -----
// Small register queue that holds pooled words until the output side takes them.
module wpool_fifo #(
    parameter int WIDTH = 17,
    parameter int DEPTH = wpool_pkg::OUT_DEPTH,
    localparam int PB   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CB   = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             out_valid,
    output logic [WIDTH-1:0] out_data,
    output logic [CB-1:0]    count
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PB-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PB-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CB-1:0]    count_reg, count_next;
    logic             do_pop;

    always_comb begin
        do_pop      = pop && (count_reg != '0);
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PB'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PB'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

// ----- hw/rtl/window_pooling_2d.sv -----
// Top level of the 2x2 / 3x3 max and average pooling block.
//
//   channel | direction | handshake          | carries
//   s_      | in        | s_tvalid/s_tready  | sample (tdata), tensor_start (tuser)
//   m_      | out       | m_tvalid/m_tready  | pooled_value (tdata), row_end (tlast)
//   cfg_    | in        | cfg_wr_en          | row_width, window_size, pool_mode
//
// One sample is taken per cycle while s_tready is high, which drops only when the
// four-word output queue plus words in flight would overflow. A window's pooled word
// is queued via the op and merge registers. The line store is one RAM with one read
// and one write port: the entry is read when the last column of a window arrives and
// written back the next cycle. Reset is synchronous and needs no clearing pass.
module window_pooling_2d #(
    parameter int MAX_WIDTH   = wpool_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = wpool_pkg::SAMPLE_BITS_DEF,
    localparam int TDW        = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [wpool_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [wpool_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [TDW-1:0]                      s_tdata,   // sample
    input  logic                                s_tuser,   // tensor_start
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [TDW-1:0]                      m_tdata,   // pooled_value
    output logic                                m_tlast    // row_end
);
    import wpool_pkg::*;

    localparam int SD = MAX_WIDTH / 2;
    localparam int AB = (SD > 1) ? $clog2(SD) : 1;
    localparam int AW = SAMPLE_BITS + ACC_GUARD;
    localparam int CB = $clog2(OUT_DEPTH + 1);

    wpool_cfg_t           cfg;
    wpool_op_t            op;
    logic signed [AW-1:0] op_acc;
    logic [AB-1:0]        op_idx;
    logic                 rd_en;
    logic [AB-1:0]        rd_addr;
    logic [AW-1:0]        rd_data;
    logic                 wr_en;
    logic [AB-1:0]        wr_addr;
    logic [AW-1:0]        wr_data;
    logic                 push;
    logic [SAMPLE_BITS-1:0] push_data;
    logic                 push_last;
    logic [1:0]           pending;
    logic [SAMPLE_BITS:0] fifo_data;
    logic [CB-1:0]        fifo_count;
    logic                 accept;

    assign s_tready = ({1'b0, fifo_count} + (CB + 1)'(pending)) < (CB + 1)'(OUT_DEPTH);
    assign accept   = s_tvalid && s_tready;

    wpool_ctrl #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .in_accept       (accept),
        .in_sample       ($signed(s_tdata[SAMPLE_BITS-1:0])),
        .in_tensor_start (s_tuser),
        .cfg             (cfg),
        .rd_en           (rd_en),
        .rd_addr         (rd_addr),
        .op              (op),
        .op_acc          (op_acc),
        .op_idx          (op_idx)
    );

    wpool_ram #(
        .WIDTH (AW),
        .DEPTH (SD)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    wpool_merge #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .op        (op),
        .op_acc    (op_acc),
        .op_idx    (op_idx),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .push      (push),
        .push_data (push_data),
        .push_last (push_last),
        .pending   (pending)
    );

    wpool_fifo #(
        .WIDTH (SAMPLE_BITS + 1),
        .DEPTH (OUT_DEPTH)
    ) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_last, push_data}),
        .pop       (m_tready),
        .out_valid (m_tvalid),
        .out_data  (fifo_data),
        .count     (fifo_count)
    );

    assign m_tdata = TDW'(fifo_data[SAMPLE_BITS-1:0]);
    assign m_tlast = fifo_data[SAMPLE_BITS];

endmodule

// ----- hw/rtl/wpool_checker.sv -----
// Port-level checks of the pooling block, bound to its top level.
module wpool_checker #(
    parameter int SAMPLE_BITS = wpool_pkg::SAMPLE_BITS_DEF,
    localparam int TDW        = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_tvalid,
    input logic           s_tready,
    input logic           m_tvalid,
    input logic           m_tready,
    input logic [TDW-1:0] m_tdata,
    input logic           m_tlast
);

    a_hold_stalled_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output word changed");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output word present after reset");

    a_word_follows_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 3))
        else $error("output word without a closing sample three cycles before");

    a_stall_only_when_backed_up: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled while output queue is empty");

endmodule

bind window_pooling_2d wpool_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_wpool_checker (.*);

// ----- dv/window_pooling_2d_checker.sv -----
// Checker for window_pooling_2d: tracks configuration, predicts each pooled word, compares.
module window_pooling_2d_checker
    import wpool_pkg::*;
#(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int TDW         = ((SAMPLE_BITS_DEF + 7) / 8) * 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [TDW-1:0]           s_tdata,   // sample
    input  logic                     s_tuser,   // tensor_start
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [TDW-1:0]           m_tdata,   // pooled_value
    input  logic                     m_tlast,   // row_end
    output int                       mismatches,
    output int                       pending
);

    localparam int STORE_DEPTH = MAX_WIDTH / 2;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] value;
        logic                   row_end;
    } pooled_word_t;

    logic [CFG_DATA_BITS-1:0] width_reg;
    logic [1:0]               window_reg;
    logic                     mode_reg;

    longint       line_store [STORE_DEPTH];
    longint       piece_acc;
    int unsigned  col_in_win;
    int unsigned  row_in_win;
    int unsigned  out_col;
    int unsigned  in_col;
    pooled_word_t pooled_due [$];
    int           words_seen;

    task automatic report_mismatch(input string what);
        $display("mismatch at word %0d: %s", words_seen, what);
        mismatches++;
    endtask

    function automatic longint merge_piece(input longint a, input longint b);
        if (mode_reg == MODE_AVG) begin
            return a + b;
        end
        return (b > a) ? b : a;
    endfunction

    function automatic void pool_sample(input logic signed [SAMPLE_BITS-1:0] sample,
                                        input logic tensor_start);
        int unsigned  span;
        int unsigned  width;
        int unsigned  outs;
        int unsigned  usable;
        int unsigned  slot;
        longint       x;
        longint       v;
        longint       r;
        longint       lo;
        longint       hi;
        pooled_word_t want;
        span = (window_reg == WINDOW_THREE) ? 3 : 2;
        width = width_reg;
        if (width > MAX_WIDTH) begin
            width = MAX_WIDTH;
        end
        if (width == 0) begin
            width = 1;
        end
        outs = width / span;
        usable = outs * span;
        lo = -(longint'(1) <<< (SAMPLE_BITS - 1));
        hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;

        if (tensor_start) begin
            in_col = 0;
            col_in_win = 0;
            row_in_win = 0;
            out_col = 0;
            piece_acc = 0;
        end

        x = sample;
        if (in_col < usable) begin
            piece_acc = (col_in_win == 0) ? x : merge_piece(piece_acc, x);
            col_in_win++;
            if (col_in_win >= span) begin
                slot = out_col % STORE_DEPTH;
                v = (row_in_win == 0) ? piece_acc : merge_piece(line_store[slot], piece_acc);
                line_store[slot] = v;
                if (row_in_win + 1 >= span) begin
                    r = v;
                    if (mode_reg == MODE_AVG) begin
                        if (span == 2) begin
                            r = v >>> AVG2_SHIFT;
                        end else begin
                            r = (v * longint'(AVG3_MUL)) >>> AVG3_SHIFT;
                        end
                    end
                    if (r < lo) begin
                        r = lo;
                    end
                    if (r > hi) begin
                        r = hi;
                    end
                    want.value = r[SAMPLE_BITS-1:0];
                    want.row_end = (out_col + 1 >= outs);
                    pooled_due.push_back(want);
                end
                col_in_win = 0;
                out_col++;
            end
        end

        in_col++;
        if (in_col >= width) begin
            in_col = 0;
            out_col = 0;
            col_in_win = 0;
            row_in_win = (row_in_win + 1 >= span) ? 0 : row_in_win + 1;
        end
    endfunction

    always @(posedge aclk) begin
        pooled_word_t want;
        if (!aresetn) begin
            width_reg = ROW_WIDTH_RESET;
            window_reg = WINDOW_RESET;
            mode_reg = MODE_RESET;
            piece_acc = 0;
            col_in_win = 0;
            row_in_win = 0;
            out_col = 0;
            in_col = 0;
            pooled_due.delete();
            words_seen = 0;
            mismatches = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_ROW_WIDTH: begin
                        width_reg = cfg_wdata;
                    end
                    CFG_WINDOW_SIZE: begin
                        window_reg = cfg_wdata[1:0];
                    end
                    CFG_POOL_MODE: begin
                        mode_reg = cfg_wdata[0];
                    end
                    default: begin
                    end
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (pooled_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %h last %b", m_tdata, m_tlast));
                end else begin
                    want = pooled_due.pop_front();
                    if (m_tdata[SAMPLE_BITS-1:0] !== want.value) begin
                        report_mismatch($sformatf("pooled_value %0d expected %0d",
                            $signed(m_tdata[SAMPLE_BITS-1:0]), $signed(want.value)));
                    end
                    if (m_tlast !== want.row_end) begin
                        report_mismatch($sformatf("row_end %b expected %b",
                            m_tlast, want.row_end));
                    end
                end
                words_seen++;
            end
            if (s_tvalid && s_tready) begin
                pool_sample(s_tdata[SAMPLE_BITS-1:0], s_tuser);
            end
        end
        pending = pooled_due.size();
    end

endmodule

// ----- dv/testbench.sv -----
// Top of the window_pooling_2d testbench: clock, reset, stimulus, idling and verdict.
module testbench;
    import wpool_pkg::*;

    localparam int SAMPLE_BITS   = SAMPLE_BITS_DEF;
    localparam int TDW           = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int RANDOM_WORDS  = 1150;
    localparam int CALM_WORDS    = 1000;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 1000;

    localparam logic [1:0] WINDOW_CODE0 = 2'd0;
    localparam logic [1:0] WINDOW_CODE1 = 2'd1;
    localparam logic [1:0] WINDOW_TWO   = WINDOW_RESET;
    localparam logic       MODE_MAX     = MODE_RESET;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
    logic                     s_tvalid  = 1'b0;
    logic [TDW-1:0]           s_tdata   = '0;
    logic                     s_tuser   = 1'b0;
    logic                     m_tready  = 1'b0;
    logic                     s_tready;
    logic                     m_tvalid;
    logic [TDW-1:0]           m_tdata;
    logic                     m_tlast;

    int   mismatches;
    int   pending;
    int   gap_odds    = 0;
    int   stall_odds  = 0;
    logic calm        = 1'b0;
    int   stall_left  = 0;
    int   idle_cycles = 0;

    window_pooling_2d uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    window_pooling_2d_checker #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TDW         (TDW)
    ) pool_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && stall_odds != 0 && $urandom_range(1, 100) <= stall_odds) begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("FAIL window_pooling_2d");
        $finish;
    end

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return SAMPLE_BITS'($urandom_range(0, 8)) - SAMPLE_BITS'(4);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic configure(input int width, input logic [1:0] win, input logic mode);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_ROW_WIDTH;
        cfg_wdata <= CFG_DATA_BITS'(width);
        @(posedge aclk);
        cfg_index <= CFG_WINDOW_SIZE;
        cfg_wdata <= CFG_DATA_BITS'(win);
        @(posedge aclk);
        cfg_index <= CFG_POOL_MODE;
        cfg_wdata <= CFG_DATA_BITS'(mode);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_word(input logic [SAMPLE_BITS-1:0] value, input logic first);
        if (!calm && gap_odds != 0 && $urandom_range(1, 100) <= gap_odds) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDW'(value);
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic await_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int         i;
        int         span;
        int         width;
        int         rows;
        int         phase;
        int         random_words;
        logic [1:0] win;
        logic       mode;
        random_words = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        gap_odds = 20;
        stall_odds = 20;
        configure(4, WINDOW_CODE0, MODE_MAX);
        send_word(SAMPLE_MAX, 1'b1);
        send_word(SAMPLE_MIN, 1'b0);
        send_word(SAMPLE_MIN, 1'b0);
        send_word('0, 1'b0);
        await_results();
        // switch to average in the middle of a window band
        configure(4, WINDOW_CODE0, MODE_AVG);
        send_word('1, 1'b0);
        send_word(SAMPLE_MIN, 1'b0);
        send_word(SAMPLE_MIN, 1'b0);
        send_word(SAMPLE_MIN, 1'b0);
        await_results();
        configure(8, WINDOW_CODE1, MODE_MAX);
        for (i = 0; i < 6; i++) begin
            send_word(pick_sample(), i == 0);
        end
        await_results();
        // shrink the row inside a row so the column counter wraps
        configure(4, WINDOW_CODE1, MODE_MAX);
        for (i = 0; i < 5; i++) begin
            send_word(pick_sample(), 1'b0);
        end
        await_results();
        configure(3, WINDOW_THREE, MODE_AVG);
        for (i = 0; i < 9; i++) begin
            send_word(SAMPLE_MIN, i == 0);
        end
        await_results();
        configure(2, WINDOW_THREE, MODE_MAX);
        for (i = 0; i < 3; i++) begin
            send_word(pick_sample(), i == 0);
        end
        await_results();
        configure(0, WINDOW_TWO, MODE_AVG);
        send_word(pick_sample(), 1'b1);
        send_word(pick_sample(), 1'b0);
        await_results();

        phase = 0;
        while (random_words < RANDOM_WORDS) begin
            case ($urandom_range(0, 2))
                0: gap_odds = 0;
                1: gap_odds = 15;
                default: gap_odds = 40;
            endcase
            case ($urandom_range(0, 2))
                0: stall_odds = 0;
                1: stall_odds = 15;
                default: stall_odds = 40;
            endcase
            if (phase == 2) begin
                configure(256, WINDOW_TWO, 1'($urandom_range(0, 1)));
                for (i = 0; i < 512; i++) begin
                    send_word(pick_sample(), i == 0);
                    random_words++;
                    calm = (random_words >= CALM_WORDS);
                end
            end else if (phase == 5) begin
                configure(2047, WINDOW_TWO, 1'($urandom_range(0, 1)));
                for (i = 0; i < 40; i++) begin
                    send_word(pick_sample(), i == 0);
                    random_words++;
                    calm = (random_words >= CALM_WORDS);
                end
            end else begin
                win = $urandom_range(0, 1) ? WINDOW_THREE : 2'($urandom_range(0, 2));
                mode = 1'($urandom_range(0, 1));
                span = (win == WINDOW_THREE) ? 3 : 2;
                case ($urandom_range(0, 9))
                    0: width = $urandom_range(0, span - 1);
                    1, 2: width = span * $urandom_range(1, 8) + $urandom_range(1, span - 1);
                    default: width = span * $urandom_range(1, 8);
                endcase
                rows = span * $urandom_range(1, 3);
                if ($urandom_range(0, 5) == 0) begin
                    rows += $urandom_range(1, span - 1);
                end
                configure(width, win, mode);
                for (i = 0; i < rows * ((width == 0) ? 1 : width); i++) begin
                    send_word(pick_sample(), i == 0 || $urandom_range(0, 149) == 0);
                    random_words++;
                    calm = (random_words >= CALM_WORDS);
                end
            end
            await_results();
            phase++;
        end

        repeat (20) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("PASS window_pooling_2d");
        end else begin
            $display("FAIL window_pooling_2d");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/wpool_pkg.sv
hw/rtl/wpool_ram.sv
hw/rtl/wpool_ctrl.sv
hw/rtl/wpool_merge.sv
hw/rtl/wpool_fifo.sv
hw/rtl/window_pooling_2d.sv
hw/rtl/wpool_checker.sv
dv/window_pooling_2d_checker.sv
dv/testbench.sv
